// File: sv/multiscale_ema_rnn_cell_macros.svh
// Assertion macros shared by the multiscale EMA RNN cell RTL.
`ifndef MULTISCALE_EMA_RNN_CELL_MACROS_SVH
`define MULTISCALE_EMA_RNN_CELL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MER_ASSERT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mer assertion failed");

`endif

// File: sv/mer_pkg.sv
// Package: types, codes, defaults and fixed-point functions of the EMA RNN cell.
`default_nettype none
package mer_pkg;

	localparam int N_BANKS_DEF   = 4;
	localparam int MAX_DIM_DEF   = 256;
	localparam int MAX_BATCH_DEF = 4;
	localparam int N_GATES       = 4;
	localparam int APB_AW        = 3;

	// Commands
	localparam logic [1:0] CMD_STEP       = 2'd0;
	localparam logic [1:0] CMD_LOAD_BIAS  = 2'd1;
	localparam logic [1:0] CMD_LOAD_DECAY = 2'd2;
	localparam logic [1:0] CMD_LOAD_MEM   = 2'd3;

	// Register indexes
	localparam logic CFG_BANKS = 1'b0;
	localparam logic CFG_EMIT  = 1'b1;

	typedef struct packed {
		logic [1:0]         command;
		logic [1:0]         batch_index;
		logic [7:0]         dim_index;
		logic [1:0]         bank;
		logic signed [15:0] load_value;
		logic signed [15:0] wx_sum;
		logic signed [15:0] recurrent_sum;
		logic signed [15:0] gate_hidden;
		logic [3:0][15:0]   gate_bank;
	} mer_item_t;

	typedef struct packed {
		logic signed [13:0] hidden;
		logic signed [15:0] preactivation;
		logic signed [15:0] gated_out;
	} mer_result_t;

	typedef struct packed {
		logic [2:0] banks_in_use;
		logic       emit_preactivation;
	} mer_cfg_t;

	// tanh breakpoints at k*0.25, Q0.12
	function automatic logic [12:0] tanh_pt(input logic [5:0] k);
		case (k)
			6'd0:  return 13'd0;
			6'd1:  return 13'd1003;
			6'd2:  return 13'd1893;
			6'd3:  return 13'd2602;
			6'd4:  return 13'd3119;
			6'd5:  return 13'd3475;
			6'd6:  return 13'd3707;
			6'd7:  return 13'd3856;
			6'd8:  return 13'd3949;
			6'd9:  return 13'd4006;
			6'd10: return 13'd4041;
			6'd11: return 13'd4062;
			6'd12: return 13'd4076;
			6'd13: return 13'd4084;
			6'd14: return 13'd4089;
			6'd15: return 13'd4091;
			6'd16: return 13'd4093;
			6'd17: return 13'd4094;
			6'd18: return 13'd4095;
			6'd19: return 13'd4095;
			default: return 13'd4096;
		endcase
	endfunction

	// tanh of a magnitude 0..32768, linear interpolation rounded half up
	function automatic logic [12:0] tanh_mag(input logic [15:0] mag);
		logic [5:0]  k;
		logic [9:0]  f;
		logic [12:0] p0;
		logic [12:0] p1;
		logic [20:0] prod;
		k = mag[15:10];
		f = mag[9:0];
		p0 = tanh_pt(k);
		p1 = tanh_pt(k + 6'd1);
		prod = 21'(p1 - p0) * 21'(f) + 21'd512;
		if (k >= 6'd32) return 13'd4096;
		return p0 + 13'(prod[20:10]);
	endfunction

	function automatic logic [15:0] abs16(input logic signed [15:0] x);
		logic signed [16:0] ext;
		ext = 17'(x);
		if (x[15]) ext = -ext;
		return ext[15:0];
	endfunction

	function automatic logic signed [13:0] tanh_q(input logic signed [15:0] x);
		logic [12:0] t;
		t = tanh_mag(abs16(x));
		if (x[15]) return -$signed({1'b0, t});
		return $signed({1'b0, t});
	endfunction

	// sigmoid as 0.5 +/- tanh(|x|/2)/2, Q0.12
	function automatic logic [12:0] sigmoid_q(input logic signed [15:0] x);
		logic [15:0] m;
		logic [12:0] t;
		m = abs16(x);
		t = tanh_mag({1'b0, m[15:1]});
		if (x[15]) return 13'd2048 - 13'(t[12:1]);
		return 13'd2048 + 13'(t[12:1]);
	endfunction

	// divide by 4096, nearest, ties away from zero
	function automatic logic signed [47:0] round_q12(input logic signed [47:0] v);
		logic signed [47:0] a;
		if (!v[47]) return (v + 48'sd2048) >>> 12;
		a = -v;
		a = (a + 48'sd2048) >>> 12;
		return -a;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		if (v > 48'sd32767) return 16'sh7fff;
		if (v < -48'sd32768) return 16'sh8000;
		return 16'(v);
	endfunction

endpackage
`default_nettype wire

// File: sv/mer_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module mer_ram #(
	parameter int AW = 8,
	parameter int DW = 16
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	localparam int DEPTH = 1 << AW;

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: sv/mer_cfg.sv
// APB configuration registers of the EMA RNN cell.
`default_nettype none
module mer_cfg (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [mer_pkg::APB_AW-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready,
	output mer_pkg::mer_cfg_t              cfg
);
	logic [2:0] banks_q;
	logic       emit_q;
	logic       wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			banks_q <= 3'd4;
			emit_q  <= 1'b1;
		end else if (wr) begin
			unique case (paddr[2])
				mer_pkg::CFG_BANKS: banks_q <= pwdata[2:0];
				mer_pkg::CFG_EMIT:  emit_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (paddr[2])
			mer_pkg::CFG_BANKS: prdata = {29'd0, banks_q};
			mer_pkg::CFG_EMIT:  prdata = {31'd0, emit_q};
			default:            prdata = 32'd0;
		endcase
	end

	assign cfg.banks_in_use       = banks_q;
	assign cfg.emit_preactivation = emit_q;
endmodule
`default_nettype wire

// File: sv/mer_pipe.sv
// Seven-stage datapath with bias, decay and memory stores and reset clearing pass.
`default_nettype none
`include "multiscale_ema_rnn_cell_macros.svh"
module mer_pipe #(
	parameter int N_BANKS   = mer_pkg::N_BANKS_DEF,
	parameter int MAX_DIM   = mer_pkg::MAX_DIM_DEF,
	parameter int MAX_BATCH = mer_pkg::MAX_BATCH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mer_pkg::mer_cfg_t   cfg,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire mer_pkg::mer_item_t  in_item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output mer_pkg::mer_result_t     out_res
);
	localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int BAT_W  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
	localparam int MEM_AW = DIM_W + BAT_W;

	logic en, take, hazard;
	logic clearing_q;
	logic [MEM_AW-1:0] clr_cnt_q;
	logic [3:0] act;
	logic [N_BANKS-1:0] bank_on;

	// accept decode
	logic [DIM_W-1:0] dim_a;
	logic [BAT_W-1:0] bat_a;
	logic dim_ok, bat_ok, bnk_ok;

	// valid chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	// carried control and payload
	logic step_s1, step_s2, step_s3, step_s4, step_s5, step_s6;
	logic wrb_s1, wrb_s2, wrb_s3, wrb_s4;
	logic wrd_s1, wrd_s2, wrd_s3, wrd_s4;
	logic wrm_s1, wrm_s2, wrm_s3, wrm_s4;
	logic [1:0] bank_s1, bank_s2, bank_s3, bank_s4;
	logic [DIM_W-1:0] dim_s1, dim_s2, dim_s3, dim_s4;
	logic [BAT_W-1:0] bat_s1, bat_s2, bat_s3, bat_s4;
	logic signed [15:0] load_s1, load_s2, load_s3, load_s4;
	logic signed [15:0] wx_s1, rec_s1, gh_s1;
	logic [3:0][15:0] gb_s1;
	logic signed [15:0] bias_rd;

	logic signed [15:0] pre_s2, pre_s3, pre_s4, pre_s5, pre_s6;
	logic [12:0] sigh_s2;
	logic signed [15:0] gh_s2;
	logic signed [13:0] hid_s3, hid_s4, hid_s5, hid_s6;
	logic signed [28:0] sph_s3;
	logic signed [15:0] siluh_s4;
	logic signed [29:0] ph_s5, ph_s6;

	// per-bank stage registers
	logic [15:0]        decay_rd [N_BANKS];
	logic [15:0]        mem_rd   [N_BANKS];
	logic [12:0]        alpha_s2 [N_BANKS];
	logic [12:0]        alpha_s3 [N_BANKS];
	logic signed [15:0] m_s2     [N_BANKS];
	logic signed [15:0] m_s3     [N_BANKS];
	logic [12:0]        sigb_s2  [N_BANKS];
	logic signed [15:0] g_s2     [N_BANKS];
	logic signed [28:0] spb_s3   [N_BANKS];
	logic signed [15:0] silub_s4 [N_BANKS];
	logic signed [15:0] silub_s5 [N_BANKS];
	logic signed [30:0] mixp_s4  [N_BANKS];
	logic signed [15:0] mnew_c   [N_BANKS];
	logic signed [15:0] mnew_s5  [N_BANKS];
	logic signed [31:0] pb_s6    [N_BANKS];
	logic               on_s6    [N_BANKS];
	logic signed [47:0] acc;

	logic signed [13:0] hid_s7;
	logic signed [15:0] pre_s7, gated_s7;

	assign en = !v_s7 || out_ready;

	// active bank count, saturated to the bank count
	assign act = (32'(cfg.banks_in_use) > N_BANKS) ? 4'(N_BANKS) : {1'b0, cfg.banks_in_use};

	assign dim_a  = DIM_W'(in_item.dim_index);
	assign bat_a  = BAT_W'(in_item.batch_index);
	assign dim_ok = 32'(in_item.dim_index) < MAX_DIM;
	assign bat_ok = 32'(in_item.batch_index) < MAX_BATCH;
	assign bnk_ok = 32'(in_item.bank) < N_BANKS;

	// hold an item whose dim is still on its way to the store writes
	assign hazard = (v_s1 && dim_s1 == dim_a) || (v_s2 && dim_s2 == dim_a) ||
		(v_s3 && dim_s3 == dim_a) || (v_s4 && dim_s4 == dim_a);
	assign in_ready = en && !clearing_q && !hazard;
	assign take = in_valid && in_ready;

	// clearing pass over all stores after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == {MEM_AW{1'b1}}) clearing_q <= 1'b0;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= take; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
		end
	end

	// shared payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: decoded item
			step_s1 <= in_item.command == mer_pkg::CMD_STEP && dim_ok && bat_ok;
			wrb_s1  <= in_item.command == mer_pkg::CMD_LOAD_BIAS && dim_ok;
			wrd_s1  <= in_item.command == mer_pkg::CMD_LOAD_DECAY && dim_ok && bnk_ok;
			wrm_s1  <= in_item.command == mer_pkg::CMD_LOAD_MEM && dim_ok && bat_ok && bnk_ok;
			bank_s1 <= in_item.bank;
			dim_s1  <= dim_a;
			bat_s1  <= bat_a;
			load_s1 <= in_item.load_value;
			wx_s1   <= in_item.wx_sum;
			rec_s1  <= in_item.recurrent_sum;
			gh_s1   <= in_item.gate_hidden;
			gb_s1   <= in_item.gate_bank;
			// s2: pre-activation, hidden gate sigmoid
			step_s2 <= step_s1; wrb_s2 <= wrb_s1; wrd_s2 <= wrd_s1; wrm_s2 <= wrm_s1;
			bank_s2 <= bank_s1; dim_s2 <= dim_s1; bat_s2 <= bat_s1; load_s2 <= load_s1;
			pre_s2  <= mer_pkg::sat16(48'(wx_s1) + 48'(rec_s1) + 48'(bias_rd));
			sigh_s2 <= mer_pkg::sigmoid_q(gh_s1);
			gh_s2   <= gh_s1;
			// s3: tanh, hidden gate product
			step_s3 <= step_s2; wrb_s3 <= wrb_s2; wrd_s3 <= wrd_s2; wrm_s3 <= wrm_s2;
			bank_s3 <= bank_s2; dim_s3 <= dim_s2; bat_s3 <= bat_s2; load_s3 <= load_s2;
			pre_s3  <= pre_s2;
			hid_s3  <= mer_pkg::tanh_q(pre_s2);
			sph_s3  <= 29'(gh_s2) * 29'($signed({1'b0, sigh_s2}));
			// s4: silu rounding
			step_s4 <= step_s3; wrb_s4 <= wrb_s3; wrd_s4 <= wrd_s3; wrm_s4 <= wrm_s3;
			bank_s4 <= bank_s3; dim_s4 <= dim_s3; bat_s4 <= bat_s3; load_s4 <= load_s3;
			pre_s4   <= pre_s3;
			hid_s4   <= hid_s3;
			siluh_s4 <= mer_pkg::sat16(mer_pkg::round_q12(48'(sph_s3)));
			// s5: hidden branch product
			step_s5 <= step_s4;
			pre_s5  <= pre_s4;
			hid_s5  <= hid_s4;
			ph_s5   <= 30'(hid_s4) * 30'(siluh_s4);
			// s6
			step_s6 <= step_s5;
			pre_s6  <= pre_s5;
			hid_s6  <= hid_s5;
			ph_s6   <= ph_s5;
		end
	end

	// bias store
	mer_ram #(.AW(DIM_W), .DW(16)) u_bias (
		.clk   (clk),
		.we    (clearing_q || (en && v_s4 && wrb_s4)),
		.waddr (clearing_q ? clr_cnt_q[DIM_W-1:0] : dim_s4),
		.wdata (clearing_q ? 16'd0 : load_s4),
		.re    (en),
		.raddr (dim_a),
		.rdata (bias_rd)
	);

	// memory banks
	for (genvar i = 0; i < N_BANKS; i++) begin : g_bank
		logic signed [15:0] gsel;
		logic dec_we, mem_we;

		assign bank_on[i] = 32'(act) > i;

		if (i < mer_pkg::N_GATES) begin : g_gate
			assign gsel = $signed(gb_s1[i]);
		end else begin : g_nogate
			assign gsel = 16'sd0;
		end

		assign dec_we = clearing_q || (en && v_s4 && wrd_s4 && 32'(bank_s4) == i);
		assign mem_we = clearing_q || (en && v_s4 &&
			((wrm_s4 && 32'(bank_s4) == i) || (step_s4 && bank_on[i])));

		mer_ram #(.AW(DIM_W), .DW(16)) u_decay (
			.clk   (clk),
			.we    (dec_we),
			.waddr (clearing_q ? clr_cnt_q[DIM_W-1:0] : dim_s4),
			.wdata (clearing_q ? 16'd0 : load_s4),
			.re    (en),
			.raddr (dim_a),
			.rdata (decay_rd[i])
		);

		mer_ram #(.AW(MEM_AW), .DW(16)) u_mem (
			.clk   (clk),
			.we    (mem_we),
			.waddr (clearing_q ? clr_cnt_q : {bat_s4, dim_s4}),
			.wdata (clearing_q ? 16'd0 : (wrm_s4 ? load_s4 : mnew_c[i])),
			.re    (en),
			.raddr ({bat_a, dim_a}),
			.rdata (mem_rd[i])
		);

		// new memory value: h + alpha*(m - h), rounded and saturated
		assign mnew_c[i] = mer_pkg::sat16(mer_pkg::round_q12(
			(48'(hid_s4) <<< 12) + 48'(mixp_s4[i])));

		always_ff @(posedge clk) begin
			if (en) begin
				alpha_s2[i] <= mer_pkg::sigmoid_q($signed(decay_rd[i]));
				m_s2[i]     <= $signed(mem_rd[i]);
				sigb_s2[i]  <= mer_pkg::sigmoid_q(gsel);
				g_s2[i]     <= gsel;
				alpha_s3[i] <= alpha_s2[i];
				m_s3[i]     <= m_s2[i];
				spb_s3[i]   <= 29'(g_s2[i]) * 29'($signed({1'b0, sigb_s2[i]}));
				mixp_s4[i]  <= 31'($signed({1'b0, alpha_s3[i]})) *
					31'(17'(m_s3[i]) - 17'(hid_s3));
				silub_s4[i] <= mer_pkg::sat16(mer_pkg::round_q12(48'(spb_s3[i])));
				mnew_s5[i]  <= mnew_c[i];
				silub_s5[i] <= silub_s4[i];
				pb_s6[i]    <= 32'(mnew_s5[i]) * 32'(silub_s5[i]);
				on_s6[i]    <= bank_on[i];
			end
		end
	end

	// final sum of products
	always_comb begin
		acc = 48'(ph_s6);
		for (int i = 0; i < N_BANKS; i++) begin
			if (on_s6[i]) acc = acc + 48'(pb_s6[i]);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			hid_s7   <= step_s6 ? hid_s6 : 14'sd0;
			pre_s7   <= (step_s6 && cfg.emit_preactivation) ? pre_s6 : 16'sd0;
			gated_s7 <= step_s6 ? mer_pkg::sat16(mer_pkg::round_q12(acc)) : 16'sd0;
		end
	end

	assign out_valid             = v_s7;
	assign out_res.hidden        = hid_s7;
	assign out_res.preactivation = pre_s7;
	assign out_res.gated_out     = gated_s7;

	// an item never reads a dim that the write stage is writing in the same cycle
	`MER_ASSERT(a_no_raw, clk, arst_n, take && v_s4, dim_s4 != dim_a)
	// the pipeline is empty throughout the clearing pass
	`MER_ASSERT(a_clear_empty, clk, arst_n, clearing_q, !(v_s1 || v_s2 || v_s3 || v_s4 || v_s5 || v_s6 || v_s7))
	// an accepted item enters stage one
	`MER_ASSERT_NEXT(a_enter, clk, arst_n, take, v_s1)
endmodule
`default_nettype wire

// File: sv/multiscale_ema_rnn_cell.sv
// Top level of the multiscale EMA RNN cell: stream ports, APB registers, datapath.
// Pipeline: an accepted item moves through the stage registers to the output register.
// Throughput: one item per cycle while the output is not stalled; an item whose dim
// matches an item in stages one to four (stage four writes the stores) waits until
// that item has left stage four. Reset: registers take their reset values; a clearing
// pass zeroes the stores, with no item accepted.
`default_nettype none
module multiscale_ema_rnn_cell #(
	parameter int N_BANKS   = mer_pkg::N_BANKS_DEF,
	parameter int MAX_DIM   = mer_pkg::MAX_DIM_DEF,
	parameter int MAX_BATCH = mer_pkg::MAX_BATCH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [mer_pkg::APB_AW-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// batch_index, dim_index, bank, load_value, wx_sum, recurrent_sum,
	// gate_hidden, gate_bank0, gate_bank1, gate_bank2, gate_bank3, zero pad
	input  wire logic [143:0]               s_tdata,
	// command
	input  wire logic [1:0]                 s_tuser,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// hidden, preactivation, gated_out, zero pad
	output logic      [47:0]                m_tdata
);
	mer_pkg::mer_cfg_t    cfg;
	mer_pkg::mer_item_t   item;
	mer_pkg::mer_result_t res;

	mer_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// unpack the input item
	assign item.command       = s_tuser;
	assign item.batch_index   = s_tdata[1:0];
	assign item.dim_index     = s_tdata[9:2];
	assign item.bank          = s_tdata[11:10];
	assign item.load_value    = s_tdata[27:12];
	assign item.wx_sum        = s_tdata[43:28];
	assign item.recurrent_sum = s_tdata[59:44];
	assign item.gate_hidden   = s_tdata[75:60];
	assign item.gate_bank[0]  = s_tdata[91:76];
	assign item.gate_bank[1]  = s_tdata[107:92];
	assign item.gate_bank[2]  = s_tdata[123:108];
	assign item.gate_bank[3]  = s_tdata[139:124];

	mer_pipe #(
		.N_BANKS   (N_BANKS),
		.MAX_DIM   (MAX_DIM),
		.MAX_BATCH (MAX_BATCH)
	) u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	// pack the result item
	assign m_tdata = {2'b00, res.gated_out, res.preactivation, res.hidden};
endmodule
`default_nettype wire
